FILE: rtl/packet_frame_parser_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the packet frame parser checker
// Each macro builds one clocked property that is disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef PACKET_FRAME_PARSER_CORE_MACROS_SVH
`define PACKET_FRAME_PARSER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pfp_pkg.sv
// ---------------------------------------------------------------------------
// pfp_pkg
// Types and constants shared by the packet frame parser modules.
// ---------------------------------------------------------------------------
package pfp_pkg;

	localparam int DEF_LEN_BITS = 32;
	localparam int MIN_FRAME    = 12;
	localparam int FIFO_DEPTH   = 4;
	localparam int TDATA_W      = 104;

	typedef enum logic [3:0] {
		PH_VERSION  = 4'd0,
		PH_TYPE     = 4'd1,
		PH_SIZE     = 4'd2,
		PH_AUTHKIND = 4'd3,
		PH_COUNT    = 4'd4,
		PH_WORDS    = 4'd5,
		PH_PLEN     = 4'd6,
		PH_PAYLOAD  = 4'd7,
		PH_DONE     = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		KIND_HEADER  = 3'd0,
		KIND_AUTH    = 3'd1,
		KIND_PLEN    = 3'd2,
		KIND_PAYLOAD = 3'd3,
		KIND_END     = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_SMALL = 2'd1,
		ST_MALFORMED = 2'd2,
		ST_TRUNCATED = 2'd3
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] version;
		logic [7:0]  msg_type;
		logic [31:0] declared_size;
		logic [7:0]  auth_kind;
		logic [31:0] value;
		status_t     status;
		logic        end_of_frame;
	} result_t;

	// Up to two results per input byte: a data result and an end status.
	typedef struct packed {
		logic    a_vld;
		result_t a;
		logic    b_vld;
		result_t b;
	} parse_out_t;

endpackage

FILE: rtl/pfp_res_fifo.sv
// ---------------------------------------------------------------------------
// pfp_res_fifo
// Small result queue; takes up to two results per cycle, delivers one.
// ---------------------------------------------------------------------------
module pfp_res_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  pfp_pkg::parse_out_t push,
	input  logic                rd_rdy,
	output logic                rd_vld,
	output pfp_pkg::result_t    head,
	output logic                room
);

	localparam int DEPTH = pfp_pkg::FIFO_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	pfp_pkg::result_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr0_en;
	logic             wr1_en;
	logic             pop;
	pfp_pkg::result_t wr0;
	logic [CNT_W-1:0] push_n;

	assign wr0_en = push.a_vld | push.b_vld;
	assign wr1_en = push.a_vld & push.b_vld;
	assign wr0    = push.a_vld ? push.a : push.b;
	assign push_n = CNT_W'(wr0_en) + CNT_W'(wr1_en);
	assign rd_vld = (cnt_q != '0);
	assign pop    = rd_vld & rd_rdy;
	assign head   = mem_q[rd_ptr_q];
	// Room for a full pair of results, so a request never overflows.
	assign room   = (cnt_q <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (wr0_en) begin
			mem_q[wr_ptr_q] <= wr0;
		end
		if (wr1_en) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + push_n - CNT_W'(pop);
		end
	end

endmodule

FILE: rtl/pfp_parser.sv
// ---------------------------------------------------------------------------
// pfp_parser
// Field decoder: assembles big-endian fields and builds the results of a byte.
// ---------------------------------------------------------------------------
module pfp_parser #(
	parameter int LEN_BITS = pfp_pkg::DEF_LEN_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_acc,
	input  logic [7:0]          data_byte,
	input  logic                buffer_end,
	output pfp_pkg::parse_out_t res
);

	pfp_pkg::phase_t     phase_q, phase_p, phase_nxt;
	logic [1:0]          idx_q, idx_p, idx_nxt;
	logic [31:0]         asm_q, asm_p, asm_nxt;
	logic [LEN_BITS-1:0] bytes_q, bytes_inc, bytes_nxt;
	logic [15:0]         ver_q, ver_p, ver_nxt;
	logic [7:0]          type_q, type_p, type_nxt;
	logic [31:0]         size_q, size_p, size_nxt;
	logic [7:0]          akind_q, akind_p, akind_nxt;
	logic [31:0]         words_q, words_p, words_nxt;
	logic [31:0]         pay_q, pay_p, pay_nxt;
	logic [2:0]          fld_len;
	logic [31:0]         asm_shift;
	logic                fld_done;
	pfp_pkg::status_t    status;

	always_comb begin
		unique case (phase_q) inside
			pfp_pkg::PH_VERSION:                      fld_len = 3'd2;
			pfp_pkg::PH_TYPE, pfp_pkg::PH_AUTHKIND:   fld_len = 3'd1;
			default:                                  fld_len = 3'd4;
		endcase
	end

	assign asm_shift = {asm_q[23:0], data_byte};
	assign fld_done  = (({1'b0, idx_q} + 3'd1) >= fld_len);
	assign bytes_inc = (bytes_q != {LEN_BITS{1'b1}}) ? bytes_q + LEN_BITS'(1) : bytes_q;

	// Next state of the frame decode, before the end-of-buffer restart.
	always_comb begin
		phase_p = phase_q;
		idx_p   = idx_q;
		asm_p   = asm_q;
		ver_p   = ver_q;
		type_p  = type_q;
		size_p  = size_q;
		akind_p = akind_q;
		words_p = words_q;
		pay_p   = pay_q;
		unique case (phase_q) inside
			pfp_pkg::PH_PAYLOAD: begin
				pay_p = pay_q - 32'd1;
				if (pay_q == 32'd1) begin
					phase_p = pfp_pkg::PH_DONE;
				end
			end
			pfp_pkg::PH_VERSION, pfp_pkg::PH_TYPE, pfp_pkg::PH_SIZE, pfp_pkg::PH_AUTHKIND,
			pfp_pkg::PH_COUNT, pfp_pkg::PH_WORDS, pfp_pkg::PH_PLEN: begin
				asm_p = fld_done ? 32'd0 : asm_shift;
				idx_p = fld_done ? 2'd0 : idx_q + 2'd1;
				if (fld_done) begin
					unique case (phase_q)
						pfp_pkg::PH_VERSION: begin
							ver_p   = asm_shift[15:0];
							phase_p = pfp_pkg::PH_TYPE;
						end
						pfp_pkg::PH_TYPE: begin
							type_p  = asm_shift[7:0];
							phase_p = pfp_pkg::PH_SIZE;
						end
						pfp_pkg::PH_SIZE: begin
							size_p  = asm_shift;
							phase_p = pfp_pkg::PH_AUTHKIND;
						end
						pfp_pkg::PH_AUTHKIND: begin
							akind_p = asm_shift[7:0];
							phase_p = pfp_pkg::PH_COUNT;
						end
						pfp_pkg::PH_COUNT: begin
							words_p = asm_shift;
							phase_p = (asm_shift != 32'd0) ? pfp_pkg::PH_WORDS : pfp_pkg::PH_PLEN;
						end
						pfp_pkg::PH_WORDS: begin
							words_p = words_q - 32'd1;
							if (words_q == 32'd1) begin
								phase_p = pfp_pkg::PH_PLEN;
							end
						end
						default: begin
							pay_p   = asm_shift;
							phase_p = (asm_shift != 32'd0) ? pfp_pkg::PH_PAYLOAD : pfp_pkg::PH_DONE;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// The status uses the count and phase as they stand after this byte.
	always_comb begin
		if (bytes_inc < LEN_BITS'(pfp_pkg::MIN_FRAME)) begin
			status = pfp_pkg::ST_TOO_SMALL;
		end else if (size_p > 32'(bytes_inc)) begin
			status = pfp_pkg::ST_MALFORMED;
		end else if (phase_p != pfp_pkg::PH_DONE) begin
			status = pfp_pkg::ST_TRUNCATED;
		end else begin
			status = pfp_pkg::ST_OK;
		end
	end

	always_comb begin
		if (buffer_end) begin
			phase_nxt = pfp_pkg::PH_VERSION;
			idx_nxt   = '0;
			asm_nxt   = '0;
			bytes_nxt = '0;
			ver_nxt   = '0;
			type_nxt  = '0;
			size_nxt  = '0;
			akind_nxt = '0;
			words_nxt = '0;
			pay_nxt   = '0;
		end else begin
			phase_nxt = phase_p;
			idx_nxt   = idx_p;
			asm_nxt   = asm_p;
			bytes_nxt = bytes_inc;
			ver_nxt   = ver_p;
			type_nxt  = type_p;
			size_nxt  = size_p;
			akind_nxt = akind_p;
			words_nxt = words_p;
			pay_nxt   = pay_p;
		end
	end

	// Results caused by the current request.
	always_comb begin
		res = '0;
		unique case (phase_q)
			pfp_pkg::PH_COUNT: begin
				res.a_vld           = in_acc & fld_done;
				res.a.kind          = pfp_pkg::KIND_HEADER;
				res.a.version       = ver_q;
				res.a.msg_type      = type_q;
				res.a.declared_size = size_q;
				res.a.auth_kind     = akind_q;
				res.a.value         = asm_shift;
			end
			pfp_pkg::PH_WORDS: begin
				res.a_vld   = in_acc & fld_done;
				res.a.kind  = pfp_pkg::KIND_AUTH;
				res.a.value = asm_shift;
			end
			pfp_pkg::PH_PLEN: begin
				res.a_vld   = in_acc & fld_done;
				res.a.kind  = pfp_pkg::KIND_PLEN;
				res.a.value = asm_shift;
			end
			pfp_pkg::PH_PAYLOAD: begin
				res.a_vld   = in_acc;
				res.a.kind  = pfp_pkg::KIND_PAYLOAD;
				res.a.value = {24'd0, data_byte};
			end
			default: begin
				res.a_vld  = 1'b0;
				res.a.kind = pfp_pkg::KIND_HEADER;
			end
		endcase
		res.b_vld          = in_acc & buffer_end;
		res.b.kind         = pfp_pkg::KIND_END;
		res.b.status       = status;
		res.b.end_of_frame = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pfp_pkg::PH_VERSION;
			idx_q   <= '0;
			asm_q   <= '0;
			bytes_q <= '0;
			ver_q   <= '0;
			type_q  <= '0;
			size_q  <= '0;
			akind_q <= '0;
			words_q <= '0;
			pay_q   <= '0;
		end else if (in_acc) begin
			phase_q <= phase_nxt;
			idx_q   <= idx_nxt;
			asm_q   <= asm_nxt;
			bytes_q <= bytes_nxt;
			ver_q   <= ver_nxt;
			type_q  <= type_nxt;
			size_q  <= size_nxt;
			akind_q <= akind_nxt;
			words_q <= words_nxt;
			pay_q   <= pay_nxt;
		end
	end

endmodule

FILE: rtl/packet_frame_parser_core.sv
// ---------------------------------------------------------------------------
// packet_frame_parser_core
// Byte-serial frame decoder with header, auth word, length and payload results.
// ---------------------------------------------------------------------------
// Bytes of a frame enter on the s_axis channel, one per request, with tlast
// on the final byte of the received buffer. Results leave on m_axis: tuser
// carries the result kind and tlast marks the end status of the frame.
// A result is written into the result queue as the byte that causes it is
// accepted. The decode of a byte is one pass of logic between the field
// state registers and a four-entry result queue, so one byte is taken every
// cycle while the queue has room. The last byte of a buffer can cause two
// results (its data result and the end status); the queue takes both at
// once and delivers the second after the first.
// s_axis_tready drops only while the queue holds more than two results, that
// is when the receiver stalls; accepted bytes are never lost.
// Reset clears the queue and returns the decoder to the version field.
// ---------------------------------------------------------------------------
module packet_frame_parser_core #(
	parameter int LEN_BITS = pfp_pkg::DEF_LEN_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // data_byte
	input  logic                        s_axis_tlast,  // buffer_end
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// version, msg_type, declared_size, auth_kind, value, status, zero fill
	output logic [pfp_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic [2:0]                  m_axis_tuser,  // kind
	output logic                        m_axis_tlast   // end_of_frame
);

	logic                in_acc;
	pfp_pkg::parse_out_t res;
	pfp_pkg::result_t    head;
	logic                room;

	assign s_axis_tready = room;
	assign in_acc        = s_axis_tvalid & room;

	pfp_parser #(
		.LEN_BITS(LEN_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_acc     (in_acc),
		.data_byte  (s_axis_tdata),
		.buffer_end (s_axis_tlast),
		.res        (res)
	);

	pfp_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res),
		.rd_rdy (m_axis_tready),
		.rd_vld (m_axis_tvalid),
		.head   (head),
		.room   (room)
	);

	assign m_axis_tdata = {6'd0, head.status, head.value, head.auth_kind,
		head.declared_size, head.msg_type, head.version};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.end_of_frame;

endmodule

FILE: rtl/pfp_checker.sv
// ---------------------------------------------------------------------------
// pfp_checker
// Port-level checks of the packet frame parser, bound to the top level.
// ---------------------------------------------------------------------------
`include "packet_frame_parser_core_macros.svh"

module pfp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic                        s_axis_tlast,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [pfp_pkg::TDATA_W-1:0] m_axis_tdata,
	input logic [2:0]                  m_axis_tuser,
	input logic                        m_axis_tlast
);

	// A stalled result stays in place.
	`PFP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

	// The end status is the only result that closes a frame.
	`PFP_ASSERT_SAME(a_last_kind, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == pfp_pkg::KIND_END), "tlast and end kind disagree")

	// Only the end status carries a status code.
	`PFP_ASSERT_SAME(a_status_end, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[97:96] == pfp_pkg::ST_OK, "status set on a data result")

	// Back-pressure on the input only comes from results waiting downstream.
	`PFP_ASSERT_SAME(a_ready_low, !s_axis_tready, m_axis_tvalid, "input stalled with no result pending")

	// After a byte is accepted with tlast, a result is valid in the next cycle.
	`PFP_ASSERT_NEXT(a_end_out, s_axis_tvalid && s_axis_tready && s_axis_tlast, m_axis_tvalid, "no result after buffer end")

endmodule

bind packet_frame_parser_core pfp_checker u_pfp_checker (.*);

FILE: sim/packet_frame_parser_core_test.sv
// ---------------------------------------------------------------------------
// packet_frame_parser_core_test
// Streams byte-serial frames into the parser and checks every decoded result.
// A scoreboard tracks the field decode of each accepted byte and compares the
// results on m_axis in order. Frames are mostly well formed with random
// content. Some are cut short, carry trailing bytes, declare a wrong size or
// are plain noise. Both stream sides idle at random, and the receiver holds
// off for long stretches to back up the result queue.
// ---------------------------------------------------------------------------

class frame_scoreboard;
	pfp_pkg::phase_t  field_phase;
	logic [1:0]       byte_idx;
	logic [31:0]      shift_word;
	logic [31:0]      byte_count;
	logic [15:0]      hdr_version;
	logic [7:0]       hdr_type;
	logic [31:0]      hdr_size;
	logic [7:0]       hdr_auth_kind;
	logic [31:0]      auth_left;
	logic [31:0]      payload_left;
	pfp_pkg::result_t expected_results[$];
	int               errors;
	int               checked;
	int               frames;
	int               status_count[4];

	function new();
		restart();
		errors = 0;
		checked = 0;
		frames = 0;
		foreach (status_count[i]) status_count[i] = 0;
	endfunction

	function void restart();
		field_phase = pfp_pkg::PH_VERSION;
		byte_idx = '0;
		shift_word = '0;
		byte_count = '0;
		hdr_version = '0;
		hdr_type = '0;
		hdr_size = '0;
		hdr_auth_kind = '0;
		auth_left = '0;
		payload_left = '0;
	endfunction

	function int pending();
		return expected_results.size();
	endfunction

	// Shifts one byte in; true once a field of the given length is complete.
	function logic shift_in(logic [7:0] b, int len);
		shift_word = {shift_word[23:0], b};
		if (byte_idx + 1 >= len) begin
			byte_idx = '0;
			return 1'b1;
		end
		byte_idx = byte_idx + 2'd1;
		return 1'b0;
	endfunction

	function void note_byte(logic [7:0] b, logic last);
		pfp_pkg::result_t r;
		pfp_pkg::status_t st;
		if (byte_count != '1)
			byte_count = byte_count + 32'd1;
		r = '0;
		case (field_phase)
			pfp_pkg::PH_VERSION: if (shift_in(b, 2)) begin
				hdr_version = shift_word[15:0];
				shift_word = '0;
				field_phase = pfp_pkg::PH_TYPE;
			end
			pfp_pkg::PH_TYPE: if (shift_in(b, 1)) begin
				hdr_type = shift_word[7:0];
				shift_word = '0;
				field_phase = pfp_pkg::PH_SIZE;
			end
			pfp_pkg::PH_SIZE: if (shift_in(b, 4)) begin
				hdr_size = shift_word;
				shift_word = '0;
				field_phase = pfp_pkg::PH_AUTHKIND;
			end
			pfp_pkg::PH_AUTHKIND: if (shift_in(b, 1)) begin
				hdr_auth_kind = shift_word[7:0];
				shift_word = '0;
				field_phase = pfp_pkg::PH_COUNT;
			end
			pfp_pkg::PH_COUNT: if (shift_in(b, 4)) begin
				auth_left = shift_word;
				r.kind = pfp_pkg::KIND_HEADER;
				r.version = hdr_version;
				r.msg_type = hdr_type;
				r.declared_size = hdr_size;
				r.auth_kind = hdr_auth_kind;
				r.value = shift_word;
				expected_results.push_back(r);
				shift_word = '0;
				field_phase = (auth_left != 0) ? pfp_pkg::PH_WORDS : pfp_pkg::PH_PLEN;
			end
			pfp_pkg::PH_WORDS: if (shift_in(b, 4)) begin
				r.kind = pfp_pkg::KIND_AUTH;
				r.value = shift_word;
				expected_results.push_back(r);
				shift_word = '0;
				auth_left = auth_left - 32'd1;
				if (auth_left == 0)
					field_phase = pfp_pkg::PH_PLEN;
			end
			pfp_pkg::PH_PLEN: if (shift_in(b, 4)) begin
				payload_left = shift_word;
				r.kind = pfp_pkg::KIND_PLEN;
				r.value = shift_word;
				expected_results.push_back(r);
				shift_word = '0;
				field_phase = (payload_left != 0) ? pfp_pkg::PH_PAYLOAD : pfp_pkg::PH_DONE;
			end
			pfp_pkg::PH_PAYLOAD: begin
				r.kind = pfp_pkg::KIND_PAYLOAD;
				r.value = {24'd0, b};
				expected_results.push_back(r);
				payload_left = payload_left - 32'd1;
				if (payload_left == 0)
					field_phase = pfp_pkg::PH_DONE;
			end
			default: ;
		endcase

		if (last) begin
			if (byte_count < pfp_pkg::MIN_FRAME)
				st = pfp_pkg::ST_TOO_SMALL;
			else if (hdr_size > byte_count)
				st = pfp_pkg::ST_MALFORMED;
			else if (field_phase < pfp_pkg::PH_DONE)
				st = pfp_pkg::ST_TRUNCATED;
			else
				st = pfp_pkg::ST_OK;
			r = '0;
			r.kind = pfp_pkg::KIND_END;
			r.status = st;
			r.end_of_frame = 1'b1;
			expected_results.push_back(r);
			frames++;
			status_count[st]++;
			restart();
		end
	endfunction

	function void match_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
		end
	endfunction

	function void check_result(logic [pfp_pkg::TDATA_W-1:0] d, logic [2:0] user, logic tl);
		pfp_pkg::result_t w;
		checked++;
		if (expected_results.size() == 0) begin
			errors++;
			$error("result with nothing expected: kind %0d value %0h", user, d[95:64]);
			return;
		end
		w = expected_results.pop_front();
		match_field("kind", w.kind, user);
		match_field("version", w.version, d[15:0]);
		match_field("msg_type", w.msg_type, d[23:16]);
		match_field("declared_size", w.declared_size, d[55:24]);
		match_field("auth_kind", w.auth_kind, d[63:56]);
		match_field("value", w.value, d[95:64]);
		match_field("status", w.status, d[97:96]);
		match_field("end_of_frame", w.end_of_frame, tl);
	endfunction
endclass

module packet_frame_parser_core_test;
	localparam int ITEMS      = 1800;
	localparam int LONG_HOLD  = 120;
	localparam int CYCLE_CAP  = 400000;

	logic                        clk;
	logic                        arst_n;
	logic                        s_axis_tvalid;
	logic                        s_axis_tready;
	logic [7:0]                  s_axis_tdata;
	logic                        s_axis_tlast;
	logic                        m_axis_tvalid;
	logic                        m_axis_tready;
	logic [pfp_pkg::TDATA_W-1:0] m_axis_tdata;
	logic [2:0]                  m_axis_tuser;
	logic                        m_axis_tlast;

	frame_scoreboard sb;
	logic            tx_idle;
	logic            rx_idle;
	int              holds_asked;
	int              bytes_sent;
	int              cycles;

	packet_frame_parser_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles <= CYCLE_CAP) begin
			@(posedge clk);
			cycles++;
		end
		$display("packet_frame_parser_core verification failed");
		$finish;
	end

	// Appends the low n bytes of v, most significant first.
	task automatic put_be(ref logic [7:0] fr[$], input logic [31:0] v, input int n);
		for (int k = n - 1; k >= 0; k--)
			fr.push_back(v[8*k +: 8]);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = b;
		s_axis_tlast = last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_byte(b, last);
		bytes_sent++;
		@(negedge clk);
		// Withdrawn here; a following byte sent without a gap raises it again at the same edge.
		s_axis_tvalid = 1'b0;
	endtask

	task automatic send_frame(ref logic [7:0] fr[$]);
		for (int i = 0; i < fr.size(); i++)
			send_byte(fr[i], i == fr.size() - 1);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// Mostly well-formed frames; some noise, cut buffers, trailing bytes and
	// wrong declared sizes. Huge counts or lengths always leave the frame short.
	task automatic build_frame(ref logic [7:0] fr[$]);
		logic [31:0] n_auth;
		logic [31:0] n_pay;
		logic [31:0] size;
		int          pick;
		int          cut;
		fr.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 24)) fr.push_back(8'($urandom_range(0, 255)));
			return;
		end
		n_auth = $urandom_range(0, 3);
		n_pay = $urandom_range(0, 24);
		if ($urandom_range(0, 7) == 0) begin
			if ($urandom_range(0, 1))
				n_auth = $urandom();
			else
				n_pay = $urandom();
		end
		put_be(fr, $urandom(), 2);
		put_be(fr, $urandom(), 1);
		put_be(fr, 32'd0, 4);
		put_be(fr, $urandom(), 1);
		put_be(fr, n_auth, 4);
		repeat ((n_auth > 4) ? 4 : n_auth) put_be(fr, $urandom(), 4);
		put_be(fr, n_pay, 4);
		repeat ((n_pay > 24) ? 24 : n_pay) fr.push_back(8'($urandom_range(0, 255)));
		pick = $urandom_range(0, 19);
		if (pick < 3) begin
			repeat ($urandom_range(1, 4)) fr.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 6) begin
			cut = $urandom_range(1, fr.size() - 1);
			while (fr.size() > cut) void'(fr.pop_back());
		end
		pick = $urandom_range(0, 9);
		if (pick < 6)
			size = fr.size();
		else if (pick < 8)
			size = $urandom_range(0, fr.size());
		else if (pick < 9)
			size = fr.size() + $urandom_range(1, 5);
		else
			size = $urandom();
		for (int k = 0; k < 4; k++)
			if (3 + k < fr.size())
				fr[3 + k] = size[31 - 8*k -: 8];
	endtask

	// Result side: random stalls per result, in stretches with and without.
	initial begin
		int stall;
		int taken;
		int holds_done;
		logic got;
		m_axis_tready = 1'b0;
		rx_idle = 1'b0;
		taken = 0;
		holds_done = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (holds_done < holds_asked) begin
				m_axis_tready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				holds_done++;
			end
			if (taken % 40 == 0)
				rx_idle = ($urandom_range(0, 2) != 0);
			stall = rx_idle ? $urandom_range(0, 14) : 0;
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			do begin
				@(posedge clk);
				got = m_axis_tvalid;
				if (got)
					sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
				@(negedge clk);
			end while (!got);
			taken++;
		end
	end

	initial begin
		logic [7:0] fr[$];
		int         nfr;
		sb = new();
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		tx_idle = 1'b0;
		holds_asked = 0;
		bytes_sent = 0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// A one-byte buffer is too small for any header.
		fr = '{8'hA5};
		send_frame(fr);
		// Shortest complete frame: no auth words and an empty payload.
		fr.delete();
		put_be(fr, 32'h0000FFFF, 2);
		put_be(fr, 32'h00, 1);
		put_be(fr, 32'd16, 4);
		put_be(fr, 32'hFF, 1);
		put_be(fr, 32'd0, 4);
		put_be(fr, 32'd0, 4);
		send_frame(fr);
		// Twelve bytes of ones: header with a full auth count, size too large.
		fr.delete();
		repeat (12) fr.push_back(8'hFF);
		send_frame(fr);
		wait_drained();

		nfr = 0;
		while (bytes_sent < ITEMS) begin
			build_frame(fr);
			tx_idle = ($urandom_range(0, 2) != 0);
			if (nfr == 8 || nfr == 40)
				holds_asked++;
			if ((nfr >= 8 && nfr < 12) || (nfr >= 40 && nfr < 44))
				tx_idle = 1'b0;
			if (nfr % 20 == 19)
				wait_drained();
			send_frame(fr);
			nfr++;
		end
		s_axis_tvalid = 1'b0;
		s_axis_tlast = 1'b0;

		wait_drained();
		repeat (30) @(negedge clk);
		$display("covered %0d frames, %0d bytes, %0d results checked",
			sb.frames, bytes_sent, sb.checked);
		$display("end status ok %0d, too small %0d, malformed %0d, truncated %0d",
			sb.status_count[pfp_pkg::ST_OK], sb.status_count[pfp_pkg::ST_TOO_SMALL],
			sb.status_count[pfp_pkg::ST_MALFORMED], sb.status_count[pfp_pkg::ST_TRUNCATED]);
		if (sb.errors == 0)
			$display("packet_frame_parser_core verification clean");
		else
			$display("packet_frame_parser_core verification failed");
		$finish;
	end
endmodule
